// ===== src/cam_lobe_phase_confirm_assert.svh =====
// assertion macros for the cam lobe phase confirm block
// used by the top level; expects clk and arst_n in scope
`ifndef CAM_LOBE_PHASE_CONFIRM_ASSERT_SVH
`define CAM_LOBE_PHASE_CONFIRM_ASSERT_SVH

// same-cycle implication
`define CLPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cam phase confirm check failed");

// next-cycle implication
`define CLPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cam phase confirm check failed");

`endif

// ===== src/clpc_pkg.sv =====
// shared types, constants and helper functions for the cam lobe phase confirm block
// no dependencies
package clpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int INT_W     = TIME_BITS + 8;   // tick * interval
	localparam int NUM_W     = INT_W + 9;       // 360 * tick * interval
	localparam int DEN_W     = 32 + 16;         // crank period shifted up by 16
	localparam int DIV_W     = (NUM_W > DEN_W) ? NUM_W : DEN_W;
	localparam int QUO_W     = 17;              // 16 angle bits plus overflow bit
	localparam int CNT_W     = $clog2(QUO_W);

	localparam logic [1:0] ACT_ARM  = 2'd0;
	localparam logic [1:0] ACT_EDGE = 2'd1;
	localparam logic [1:0] ACT_EVAL = 2'd2;

	localparam logic [1:0] REG_TICK   = 2'd0;
	localparam logic [1:0] REG_MINANG = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_TRIG   = 2'd3;

	localparam logic [1:0] PHASE_NONE   = 2'd0;
	localparam logic [1:0] PHASE_FIRST  = 2'd1;
	localparam logic [1:0] PHASE_SECOND = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] timestamp;
		logic        timer_continuous;
		logic        crank_period_valid;
		logic [31:0] crank_rev_us;
		logic [1:0]  expected_phase;
	} item_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        phase_locked;
		logic        sensor_error;
		logic        lobe_triggered;
		logic        phase_matched;
		logic        checks_passed;
		logic        edge_failure;
		logic [7:0]  lobe_end_events;
		logic [15:0] lobe_angle;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_SCALE,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic scale;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic needs_div;
	} sts_t;

	function automatic logic [1:0] phase_if_lobe(input logic [1:0] trig);
		logic [1:0] p;
		p = (trig == PHASE_FIRST || trig == PHASE_SECOND) ? trig : PHASE_NONE;
		return p;
	endfunction

	function automatic logic [1:0] phase_if_no_lobe(input logic [1:0] trig);
		logic [1:0] p;
		p = (trig == PHASE_FIRST) ? PHASE_SECOND :
			(trig == PHASE_SECOND) ? PHASE_FIRST : PHASE_NONE;
		return p;
	endfunction

endpackage

// ===== src/clpc_ctrl.sv =====
// sequencer for the cam lobe phase confirm block
// depends on clpc_pkg
module clpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output logic           result_valid,
	input  logic           result_ready,
	input  clpc_pkg::sts_t sts,
	output clpc_pkg::cmd_t cmd
);

	clpc_pkg::state_t state_q, state_d;
	logic [clpc_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clpc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			clpc_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				if (item_valid)
					state_d = clpc_pkg::ST_DECODE;
			end
			clpc_pkg::ST_DECODE: begin
				state_d = sts.needs_div ? clpc_pkg::ST_MUL : clpc_pkg::ST_FINISH;
			end
			clpc_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = clpc_pkg::ST_SCALE;
			end
			clpc_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				cnt_d     = clpc_pkg::CNT_W'(clpc_pkg::QUO_W - 1);
				state_d   = clpc_pkg::ST_DIV;
			end
			clpc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = clpc_pkg::ST_FINISH;
			end
			clpc_pkg::ST_FINISH: begin
				// wait for the output slot before updating state
				cmd.commit = slot_free;
				if (slot_free)
					state_d = clpc_pkg::ST_IDLE;
			end
			default: begin
				state_d = clpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/clpc_dp.sv =====
// datapath: config registers, window state, angle divider and result register
// depends on clpc_pkg
module clpc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  clpc_pkg::item_t   item,
	input  clpc_pkg::cmd_t    cmd,
	output clpc_pkg::sts_t    sts,
	output clpc_pkg::result_t result
);

	localparam int TB = clpc_pkg::TIME_BITS;

	// configuration
	logic [7:0] tick_q;
	logic [9:0] min_ang_q;
	logic [7:0] thresh_q;
	logic [1:0] trig_q;

	// window and sync state
	logic          armed_q, begin_seen_q, end_seen_q, failure_q;
	logic [TB-1:0] begin_time_q, end_time_q;
	logic [7:0]    end_count_q, match_count_q;
	logic          valid_q, error_q;

	// latched item
	logic [1:0]    act_q;
	logic [TB-1:0] ts_q;
	logic          cont_q, pvalid_q;
	logic [31:0]   period_q;
	logic [1:0]    exp_q;

	// divider
	logic [clpc_pkg::INT_W-1:0] interval_q;
	logic [clpc_pkg::DIV_W-1:0] rem_q, den_q;
	logic [clpc_pkg::QUO_W-1:0] quo_q;
	logic [clpc_pkg::NUM_W-1:0] num;
	logic [TB-1:0]              diff;
	logic                       ge;

	clpc_pkg::result_t result_q;

	// next state
	logic          n_armed, n_begin_seen, n_end_seen, n_failure;
	logic [TB-1:0] n_begin_time, n_end_time;
	logic [7:0]    n_end_count, n_match_count;
	logic          n_valid, n_error;
	logic          checks_ok;
	logic [15:0]   angle;
	logic [1:0]    detected;
	clpc_pkg::result_t res;

	assign diff  = end_time_q - begin_time_q;
	assign num   = (clpc_pkg::NUM_W'(interval_q) << 8) + (clpc_pkg::NUM_W'(interval_q) << 6)
		+ (clpc_pkg::NUM_W'(interval_q) << 5) + (clpc_pkg::NUM_W'(interval_q) << 3);
	assign ge    = rem_q >= den_q;
	assign angle = quo_q[clpc_pkg::QUO_W-1] ? 16'hFFFF : quo_q[15:0];

	assign checks_ok = pvalid_q && (begin_seen_q == end_seen_q) && !failure_q;
	assign sts.needs_div = (act_q == clpc_pkg::ACT_EVAL) && checks_ok && begin_seen_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= 8'd1;
			min_ang_q <= 10'd10;
			thresh_q  <= 8'd3;
			trig_q    <= clpc_pkg::PHASE_FIRST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clpc_pkg::REG_TICK:   tick_q    <= cfg_data[7:0];
				clpc_pkg::REG_MINANG: min_ang_q <= cfg_data;
				clpc_pkg::REG_THRESH: thresh_q  <= cfg_data[7:0];
				clpc_pkg::REG_TRIG:   trig_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			begin_seen_q  <= 1'b0;
			end_seen_q    <= 1'b0;
			failure_q     <= 1'b0;
			begin_time_q  <= '0;
			end_time_q    <= '0;
			end_count_q   <= '0;
			match_count_q <= '0;
			valid_q       <= 1'b0;
			error_q       <= 1'b1;
		end else if (cmd.commit) begin
			armed_q       <= n_armed;
			begin_seen_q  <= n_begin_seen;
			end_seen_q    <= n_end_seen;
			failure_q     <= n_failure;
			begin_time_q  <= n_begin_time;
			end_time_q    <= n_end_time;
			end_count_q   <= n_end_count;
			match_count_q <= n_match_count;
			valid_q       <= n_valid;
			error_q       <= n_error;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= item.action;
			ts_q     <= item.timestamp[TB-1:0];
			cont_q   <= item.timer_continuous;
			pvalid_q <= item.crank_period_valid;
			period_q <= item.crank_rev_us;
			exp_q    <= item.expected_phase;
		end
		if (cmd.mul)
			interval_q <= clpc_pkg::INT_W'(tick_q) * clpc_pkg::INT_W'(diff);
		if (cmd.scale) begin
			rem_q <= clpc_pkg::DIV_W'(num);
			den_q <= clpc_pkg::DIV_W'({period_q, 16'h0000});
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring step; the top bit only flags saturation
			if (ge)
				rem_q <= rem_q - den_q;
			quo_q <= {quo_q[clpc_pkg::QUO_W-2:0], ge};
			den_q <= den_q >> 1;
		end
		if (cmd.commit)
			result_q <= res;
	end

	always_comb begin
		n_armed       = armed_q;
		n_begin_seen  = begin_seen_q;
		n_end_seen    = end_seen_q;
		n_failure     = failure_q;
		n_begin_time  = begin_time_q;
		n_end_time    = end_time_q;
		n_end_count   = end_count_q;
		n_match_count = match_count_q;
		n_valid       = valid_q;
		n_error       = error_q;
		detected      = clpc_pkg::phase_if_no_lobe(trig_q);
		res           = '0;
		unique case (act_q)
			clpc_pkg::ACT_ARM: begin
				n_armed      = 1'b0;
				n_begin_seen = 1'b0;
				n_end_seen   = 1'b0;
				n_failure    = 1'b0;
				n_end_count  = '0;
			end
			clpc_pkg::ACT_EDGE: begin
				if (!cont_q || failure_q) begin
					n_failure = 1'b1;
				end else if (!armed_q) begin
					n_begin_time = ts_q;
					n_begin_seen = 1'b1;
					n_armed      = 1'b1;
				end else begin
					n_end_time = ts_q;
					n_end_seen = 1'b1;
					if (end_count_q != 8'hFF)
						n_end_count = end_count_q + 1'b1;
				end
			end
			clpc_pkg::ACT_EVAL: begin
				if (!checks_ok) begin
					n_valid       = 1'b0;
					n_error       = 1'b1;
					n_match_count = '0;
				end else begin
					res.checks_passed = 1'b1;
					if (begin_seen_q) begin
						res.lobe_angle = angle;
						if (angle > {6'd0, min_ang_q}) begin
							detected           = clpc_pkg::phase_if_lobe(trig_q);
							res.lobe_triggered = 1'b1;
						end
					end
					if (exp_q == detected) begin
						res.phase_matched = 1'b1;
						res.phase         = exp_q;
						if (match_count_q < thresh_q) begin
							n_match_count = match_count_q + 1'b1;
						end else begin
							n_valid = 1'b1;
							n_error = 1'b0;
						end
					end else begin
						n_match_count = '0;
						n_valid       = 1'b0;
						n_error       = 1'b1;
						res.phase     = detected;
					end
				end
			end
			default: ;
		endcase
		res.phase_locked    = n_valid;
		res.sensor_error    = n_error;
		res.edge_failure    = n_failure;
		res.lobe_end_events = n_end_count;
	end

endmodule

// ===== src/cam_lobe_phase_confirm.sv =====
// top level of the cam lobe phase confirm block
// depends on clpc_pkg, clpc_ctrl, clpc_dp and cam_lobe_phase_confirm_assert.svh
//
// usage
// - item channel (item_valid/item_ready/item) takes one event per beat: arm,
//   sensor edge or evaluate; code 3 is a no-op that still returns a result
// - result channel (result_valid/result_ready/result) returns exactly one beat
//   per item, in order
// - configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the
//   user must write only while no item is in flight, the block does not enforce it
// - arm, edge and evaluate without a measured lobe: after accept the sequencer
//   goes through decode and finish, commits the result, then takes the next item
// - evaluate with a measured lobe: a multiply, a scale by 360, then a 17-step
//   restoring divide by the crank period before the result is committed; no
//   new item is taken until the sequencer is back in idle
// - a finished result sits in the output register while the next item is
//   accepted and processed; if the receiver stalls, the block holds the next
//   result (and its state update) until the output register frees up
// - reset: registers take their reset values, phase not valid, sensor error set
module cam_lobe_phase_confirm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  clpc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output clpc_pkg::result_t result
);

	`include "cam_lobe_phase_confirm_assert.svh"

	clpc_pkg::cmd_t cmd;   // sequencer commands to the datapath
	clpc_pkg::sts_t sts;   // datapath status back to the sequencer

	// state machine: decode, optional multiply/scale/divide, then commit
	clpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// config, window state, angle divider and the output register
	clpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	// the block goes busy right after taking a beat
	`CLPC_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)
	// valid and error flags always move together in opposite sense
	`CLPC_ASSERT_NOW(a_valid_vs_error, result_valid, result.phase_locked != result.sensor_error)
	// trigger or match only comes from an evaluation that passed its checks
	`CLPC_ASSERT_NOW(a_checks_first,
		result_valid && (result.lobe_triggered || result.phase_matched), result.checks_passed)
	// failed or skipped checks leave the phase at PHASE_NONE
	`CLPC_ASSERT_NOW(a_phase_needs_checks,
		result_valid && !result.checks_passed, result.phase == clpc_pkg::PHASE_NONE)

endmodule

// ===== dv/clpc_phase_checker.sv =====
`timescale 1ns / 1ps
// checker for the cam lobe phase confirm testbench: watches config writes and both beat channels,
// mirrors the window and phase state and compares every result beat field by field
// depends on clpc_pkg
module clpc_phase_checker
	import clpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      outstanding,
	output int      mismatches
);

	// mirrored registers
	logic [7:0] cfg_tick_us;
	logic [9:0] cfg_min_deg;
	logic [7:0] cfg_sync_needed;
	logic [1:0] cfg_lobe_phase;

	// mirrored window and phase state
	logic                 lobe_open;
	logic                 rise_seen;
	logic                 fall_seen;
	logic                 edge_fault;
	logic [TIME_BITS-1:0] rise_stamp;
	logic [TIME_BITS-1:0] fall_stamp;
	logic [7:0]           fall_count;
	logic [7:0]           agree_count;
	logic                 confirmed;
	logic                 cam_error;

	result_t phase_outcomes_due[$];
	int      fail_tally;

	function automatic result_t predict_phase_outcome(input item_t ev);
		result_t              r;
		logic [1:0]           lobe_side;
		logic [1:0]           quiet_side;
		logic [1:0]           detected;
		logic [TIME_BITS-1:0] span;
		logic [63:0]          scaled;
		logic [63:0]          quot;
		r = '0;
		case (cfg_lobe_phase)
			PHASE_FIRST: begin
				lobe_side  = PHASE_FIRST;
				quiet_side = PHASE_SECOND;
			end
			PHASE_SECOND: begin
				lobe_side  = PHASE_SECOND;
				quiet_side = PHASE_FIRST;
			end
			default: begin
				lobe_side  = PHASE_NONE;
				quiet_side = PHASE_NONE;
			end
		endcase
		case (ev.action)
			ACT_ARM: begin
				lobe_open  = 1'b0;
				rise_seen  = 1'b0;
				fall_seen  = 1'b0;
				edge_fault = 1'b0;
				fall_count = '0;
			end
			ACT_EDGE: begin
				if (!ev.timer_continuous || edge_fault) begin
					edge_fault = 1'b1;
				end else if (!lobe_open) begin
					rise_stamp = ev.timestamp[TIME_BITS-1:0];
					rise_seen  = 1'b1;
					lobe_open  = 1'b1;
				end else begin
					fall_stamp = ev.timestamp[TIME_BITS-1:0];
					fall_seen  = 1'b1;
					if (fall_count != 8'hFF)
						fall_count = fall_count + 8'd1;
				end
			end
			ACT_EVAL: begin
				if (!ev.crank_period_valid || rise_seen != fall_seen || edge_fault) begin
					confirmed   = 1'b0;
					cam_error   = 1'b1;
					agree_count = '0;
				end else begin
					r.checks_passed = 1'b1;
					detected = quiet_side;
					if (rise_seen && fall_seen) begin
						// wrap-safe interval, scaled to microseconds and then degrees
						span   = fall_stamp - rise_stamp;
						scaled = 64'd360 * 64'(cfg_tick_us) * 64'(span);
						if (ev.crank_rev_us == '0) begin
							r.lobe_angle = 16'hFFFF;
						end else begin
							quot = scaled / 64'(ev.crank_rev_us);
							r.lobe_angle = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
						end
						if (r.lobe_angle > 16'(cfg_min_deg)) begin
							detected = lobe_side;
							r.lobe_triggered = 1'b1;
						end
					end
					if (ev.expected_phase == detected) begin
						r.phase_matched = 1'b1;
						r.phase = ev.expected_phase;
						if (agree_count < cfg_sync_needed) begin
							agree_count = agree_count + 8'd1;
						end else begin
							confirmed = 1'b1;
							cam_error = 1'b0;
						end
					end else begin
						agree_count = '0;
						confirmed   = 1'b0;
						cam_error   = 1'b1;
						r.phase     = detected;
					end
				end
			end
			default: ;
		endcase
		r.phase_locked    = confirmed;
		r.sensor_error    = cam_error;
		r.edge_failure    = edge_fault;
		r.lobe_end_events = fall_count;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", fname, want, got);
			fail_tally++;
		end
	endtask

	task automatic compare_outcome(input result_t want, input result_t got);
		check_field("phase", want.phase, got.phase);
		check_field("phase_locked", want.phase_locked, got.phase_locked);
		check_field("sensor_error", want.sensor_error, got.sensor_error);
		check_field("lobe_triggered", want.lobe_triggered, got.lobe_triggered);
		check_field("phase_matched", want.phase_matched, got.phase_matched);
		check_field("checks_passed", want.checks_passed, got.checks_passed);
		check_field("edge_failure", want.edge_failure, got.edge_failure);
		check_field("lobe_end_events", want.lobe_end_events, got.lobe_end_events);
		check_field("lobe_angle", want.lobe_angle, got.lobe_angle);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_tick_us     = 8'd1;
			cfg_min_deg     = 10'd10;
			cfg_sync_needed = 8'd3;
			cfg_lobe_phase  = PHASE_FIRST;
			lobe_open       = 1'b0;
			rise_seen       = 1'b0;
			fall_seen       = 1'b0;
			edge_fault      = 1'b0;
			rise_stamp      = '0;
			fall_stamp      = '0;
			fall_count      = '0;
			agree_count     = '0;
			confirmed       = 1'b0;
			cam_error       = 1'b1;
			phase_outcomes_due.delete();
			fail_tally      = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			// a result beat always belongs to an earlier item, so compare first
			if (result_valid && result_ready) begin
				if (phase_outcomes_due.size() == 0) begin
					$error("result beat with no outcome pending");
					fail_tally++;
				end else begin
					compare_outcome(phase_outcomes_due.pop_front(), result);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TICK:   cfg_tick_us     = cfg_data[7:0];
					REG_MINANG: cfg_min_deg     = cfg_data;
					REG_THRESH: cfg_sync_needed = cfg_data[7:0];
					REG_TRIG:   cfg_lobe_phase  = cfg_data[1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				phase_outcomes_due.push_back(predict_phase_outcome(item));
			outstanding <= phase_outcomes_due.size();
			mismatches  <= fail_tally;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// top of the cam lobe phase confirm testbench: clock, reset, config writes, beat stimulus
// and the verdict; depends on clpc_pkg, cam_lobe_phase_confirm and clpc_phase_checker
module tb;
	import clpc_pkg::*;

	// the block answers this action code with an untouched state
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam int HOLD_CYCLES = 80;
	localparam int SEG_EVENTS  = 65;
	localparam int NUM_SEGS    = 7;

	// one register setting per random segment, extremes included
	localparam logic [7:0] SEG_TICK [NUM_SEGS] = '{8'd1, 8'd255, 8'd7, 8'd1, 8'd20, 8'd3, 8'd128};
	localparam logic [9:0] SEG_MIN [NUM_SEGS] =
		'{10'd0, 10'd720, 10'd10, 10'd90, 10'd360, 10'd45, 10'd180};
	localparam logic [7:0] SEG_THR [NUM_SEGS] = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd5, 8'd2, 8'd0};
	localparam logic [1:0] SEG_TRIG [NUM_SEGS] = '{PHASE_FIRST, PHASE_SECOND, PHASE_SECOND,
		PHASE_FIRST, PHASE_SECOND, PHASE_FIRST, PHASE_SECOND};

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_we       = 1'b0;
	logic [1:0] cfg_index    = REG_TICK;
	logic [9:0] cfg_data     = '0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	item_t      item         = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result;
	int         outstanding;
	int         mismatches;

	// idle rates of the two sides, in cycles out of a hundred
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long receiver hold-off: the stimulus bumps hold_req, the receiver counts it out
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// register values last written, used to aim the stimulus
	logic [7:0] cur_tick = 8'd1;
	logic [9:0] cur_min  = 10'd10;
	logic [1:0] cur_trig = PHASE_FIRST;

	int events_sent = 0;

	cam_lobe_phase_confirm DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	clpc_phase_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// every field random; the callers override what matters
	function automatic item_t noise_event();
		item_t ev;
		ev.action             = 2'($urandom_range(3, 0));
		ev.timestamp          = $urandom;
		ev.timer_continuous   = 1'($urandom_range(1, 0));
		ev.crank_period_valid = 1'($urandom_range(1, 0));
		ev.crank_rev_us       = $urandom;
		ev.expected_phase     = 2'($urandom_range(2, 0));
		return ev;
	endfunction

	// offer one beat, with random sender gaps before it; valid stays up after
	// acceptance so back-to-back beats never lower and raise it in one step
	task automatic send_event(input item_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= ev;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		events_sent++;
	endtask

	task automatic post_arm();
		item_t ev;
		ev = noise_event();
		ev.action = ACT_ARM;
		send_event(ev);
	endtask

	task automatic post_edge(input logic [31:0] ts, input logic cont);
		item_t ev;
		ev = noise_event();
		ev.action           = ACT_EDGE;
		ev.timestamp        = ts;
		ev.timer_continuous = cont;
		send_event(ev);
	endtask

	task automatic post_eval(input logic pvalid, input logic [31:0] period, input logic [1:0] exp_ph);
		item_t ev;
		ev = noise_event();
		ev.action             = ACT_EVAL;
		ev.crank_period_valid = pvalid;
		ev.crank_rev_us       = period;
		ev.expected_phase     = exp_ph;
		send_event(ev);
	endtask

	task automatic post_spare();
		item_t ev;
		ev = noise_event();
		ev.action = ACT_SPARE;
		send_event(ev);
	endtask

	// stop offering and wait for every outstanding result beat
	task automatic settle_block();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic [7:0] tick, input logic [9:0] min_deg,
		input logic [7:0] thr, input logic [1:0] trig);
		put_reg(REG_TICK, 10'(tick));
		put_reg(REG_MINANG, min_deg);
		put_reg(REG_THRESH, 10'(thr));
		put_reg(REG_TRIG, 10'(trig));
		cfg_we   <= 1'b0;
		cur_tick = tick;
		cur_min  = min_deg;
		cur_trig = trig;
	endtask

	// phase the stimulus aims for, so that match runs get long enough to confirm
	function automatic logic [1:0] aimed_phase(input logic lobe);
		logic [1:0] p;
		case (cur_trig)
			PHASE_FIRST:  p = lobe ? PHASE_FIRST : PHASE_SECOND;
			PHASE_SECOND: p = lobe ? PHASE_SECOND : PHASE_FIRST;
			default:      p = PHASE_NONE;
		endcase
		return p;
	endfunction

	// one cam window: arm, lobe begin, bouncing lobe end, evaluate
	task automatic run_window();
		logic [31:0] period;
		logic [31:0] span;
		logic [31:0] rise;
		logic [63:0] wide;
		logic [1:0]  exp_ph;
		logic        lobe;
		int unsigned target;
		int unsigned shape;
		int unsigned nends;
		int          k;
		if ($urandom_range(99) < 90)
			post_arm();
		case ($urandom_range(19))
			0:       period = '0;
			1:       period = $urandom;
			default: period = $urandom_range(2_000_000, 2000);
		endcase
		// aim the lobe angle around the minimum, then back out the tick count
		target = $urandom_range(int'(cur_min) + 120, 0);
		if (period == '0) begin
			span = $urandom_range(1000, 1);
		end else begin
			wide = (64'(target) * 64'(period)) / (64'd360 * 64'(cur_tick));
			span = wide[31:0];
		end
		rise  = $urandom;
		shape = $urandom_range(99);
		nends = $urandom_range(4, 1);
		if (shape >= 6) begin
			post_edge(rise, $urandom_range(99) >= 4);
			// only begin seen below 12: a precondition failure
			if (shape >= 12) begin
				for (k = 1; k <= int'(nends); k++) begin
					wide = (64'(span) * 64'(k)) / 64'(nends);
					post_edge(rise + wide[31:0], $urandom_range(99) >= 4);
				end
			end
		end
		lobe   = (shape >= 12) && (period == '0 || target > int'(cur_min));
		exp_ph = ($urandom_range(99) < 85) ? aimed_phase(lobe) : 2'($urandom_range(2, 0));
		post_eval($urandom_range(99) >= 5, period, exp_ph);
		// evaluating the same window again keeps counting matches
		if ($urandom_range(99) < 20)
			post_eval(1'b1, period, exp_ph);
		// a stray edge after the evaluate lands in the closed window
		if ($urandom_range(99) < 5)
			post_edge($urandom, 1'b1);
	endtask

	// lobe end count saturation: a long bounce burst
	task automatic run_bounce_burst();
		logic [31:0] rise;
		int          k;
		rise = $urandom;
		post_arm();
		post_edge(rise, 1'b1);
		for (k = 1; k <= 258; k++)
			post_edge(rise + 32'(k), 1'b1);
		post_eval(1'b1, 32'd100000, 2'($urandom_range(2, 0)));
	endtask

	initial begin
		int seg_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles more lightly than the receiver first
		send_idle_pct = 34;
		recv_idle_pct <= 48;

		// directed part, reset register values
		post_eval(1'b1, 32'd50000, PHASE_SECOND);        // no edges: angle not measured
		post_eval(1'b0, 32'd50000, PHASE_SECOND);        // crank period not valid
		post_spare();                                     // unused action code
		post_arm();
		post_edge(32'hFFFF_FFF0, 1'b1);                  // lobe begin just before wrap
		post_eval(1'b1, 32'd50000, PHASE_FIRST);         // only begin seen
		post_edge(32'h0000_0100, 1'b1);                  // lobe end after timer wrap
		post_edge(32'h0000_0200, 1'b1);                  // bounce
		post_eval(1'b1, 32'd0, PHASE_FIRST);             // zero crank period
		post_eval(1'b1, 32'hFFFF_FFFF, PHASE_FIRST);     // longest period, no lobe, mismatch
		post_arm();
		post_edge(32'h0000_0000, 1'b1);
		post_edge(32'hFFFF_FFFF, 1'b1);                  // widest interval
		post_eval(1'b1, 32'd1, PHASE_FIRST);             // angle overflow
		post_edge($urandom, 1'b0);                       // timer not continuous
		post_edge($urandom, 1'b1);                       // edge after a failure
		post_eval(1'b1, 32'd50000, PHASE_FIRST);         // failure blocks the evaluate
		post_arm();
		post_edge(32'd1000, 1'b1);
		post_edge(32'd1001, 1'b1);
		post_eval(1'b1, 32'd36000, PHASE_SECOND);        // short lobe, below minimum

		// meaningless triggered phase settings
		settle_block();
		write_settings(8'd1, 10'd10, 8'd3, PHASE_NONE);
		post_eval(1'b1, 32'd36000, PHASE_NONE);
		post_eval(1'b1, 32'd0, PHASE_NONE);
		settle_block();
		write_settings(8'd1, 10'd10, 8'd3, 2'd3);
		post_eval(1'b1, 32'd0, PHASE_FIRST);

		// random part, one register setting per segment
		for (int s = 0; s < NUM_SEGS; s++) begin
			settle_block();
			write_settings(SEG_TICK[s], SEG_MIN[s], SEG_THR[s], SEG_TRIG[s]);
			if (s < 3) begin
				send_idle_pct = 34;
				recv_idle_pct <= 48;
			end else if (s < 5) begin
				send_idle_pct = 48;
				recv_idle_pct <= 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			// receiver holds off while the sender keeps offering beats
			if (s == 1 || s == 5)
				hold_req <= hold_req + 1;
			seg_start = events_sent;
			if (s == 5)
				run_bounce_burst();
			while (events_sent - seg_start < SEG_EVENTS) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(4, 1)) send_event(noise_event());
				else
					run_window();
			end
		end

		// drain, leave room for a late stray beat, then give the verdict
		settle_block();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/clpc_pkg.sv
src/clpc_ctrl.sv
src/clpc_dp.sv
src/cam_lobe_phase_confirm.sv
dv/clpc_phase_checker.sv
dv/tb.sv
